// File: design/bit_field_packer_macros.svh
// Assertion helpers used by bfp_back.
`ifndef BIT_FIELD_PACKER_MACROS_SVH
`define BIT_FIELD_PACKER_MACROS_SVH

// Condition must hold in the same cycle as the trigger.
`define BFP_ASSERT_NOW(lbl, ck, rn, trig, cond) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (trig) |-> (cond)) \
        else $error("bit_field_packer: same-cycle check failed");

// Condition must hold in the cycle after the trigger.
`define BFP_ASSERT_NEXT(lbl, ck, rn, trig, cond) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (trig) |=> (cond)) \
        else $error("bit_field_packer: next-cycle check failed");

`endif

// File: design/bfp_pkg.sv
package bfp_pkg;

    localparam int VALUE_WIDTH_DEF = 64;
    localparam int CFG_LEN_W       = 7;
    localparam int QUEUE_DEPTH     = 2;

    localparam logic [CFG_LEN_W-1:0] BIT_LENGTH_RST = 7'd8;
    localparam logic                 LSB_FIRST_RST  = 1'b0;

    typedef enum logic
    {
        REG_BIT_LENGTH = 1'b0,
        REG_LSB_FIRST  = 1'b1
    } reg_idx_t;

    typedef struct packed
    {
        logic [CFG_LEN_W-1:0] bit_length;
        logic                 lsb_first;
    } bfp_cfg_t;

    function automatic logic [7:0] rev8(input logic [7:0] b);
        logic [7:0] r;
        for (int i = 0; i < 8; i++)
        begin
            r[i] = b[7-i];
        end
        return r;
    endfunction

endpackage

// File: design/bfp_front.sv
module bfp_front
    import bfp_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
    parameter int LEN_W       = $clog2(VALUE_WIDTH + 1)
)
(
    input  bfp_cfg_t                 cfg,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [VALUE_WIDTH-1:0]   value_in,
    input  logic                     final_value,
    input  logic                     q_full,
    output logic                     q_wr,
    output logic [VALUE_WIDTH-1:0]   item_stream,
    output logic [LEN_W-1:0]         item_len,
    output logic                     item_fin,
    output logic                     item_lsb
);

    logic [LEN_W-1:0]       len;
    logic [VALUE_WIDTH-1:0] rev;
    logic [VALUE_WIDTH-1:0] mask;
    logic [LEN_W-1:0]       msb_shift;

    // Saturate the length to the value width.
    always_comb
    begin
        if (cfg.bit_length > CFG_LEN_W'(VALUE_WIDTH))
            len = LEN_W'(VALUE_WIDTH);
        else
            len = cfg.bit_length[LEN_W-1:0];
    end

    always_comb
    begin
        for (int i = 0; i < VALUE_WIDTH; i++)
        begin
            rev[i] = value_in[VALUE_WIDTH-1-i];
        end
    end

    always_comb
    begin
        if (len >= LEN_W'(VALUE_WIDTH))
            mask = '1;
        else
            mask = (VALUE_WIDTH'(1) << len) - VALUE_WIDTH'(1);
    end

    assign msb_shift = LEN_W'(VALUE_WIDTH) - len;

    // Put the used bits in transmit order, first bit in bit 0.
    always_comb
    begin
        if (cfg.lsb_first)
            item_stream = value_in & mask;
        else
            item_stream = rev >> msb_shift;
    end

    assign item_len = len;
    assign item_fin = final_value;
    assign item_lsb = cfg.lsb_first;
    assign in_ready = !q_full;
    assign q_wr     = in_valid && !q_full;

endmodule

// File: design/bfp_queue.sv
module bfp_queue
    import bfp_pkg::*;
#(
    parameter int DATA_W = 8
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  logic [DATA_W-1:0] din,
    output logic              full,
    output logic              rd_valid,
    input  logic              rd_en,
    output logic [DATA_W-1:0] dout
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [DATA_W-1:0] mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_wr, do_rd;

    assign full     = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign dout     = mem_reg[rd_ptr_reg];
    assign do_wr    = wr_en && !full;
    assign do_rd    = rd_en && rd_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            if (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1))
                wr_ptr_next = '0;
            else
                wr_ptr_next = wr_ptr_reg + PTR_W'(1);
        end
        if (do_rd)
        begin
            if (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1))
                rd_ptr_next = '0;
            else
                rd_ptr_next = rd_ptr_reg + PTR_W'(1);
        end
        if (do_wr && !do_rd)
            count_next = count_reg + CNT_W'(1);
        else if (do_rd && !do_wr)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem_reg[wr_ptr_reg] <= din;
    end

endmodule

// File: design/bfp_back.sv
`include "bit_field_packer_macros.svh"

module bfp_back
    import bfp_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
    parameter int LEN_W       = $clog2(VALUE_WIDTH + 1)
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   q_valid,
    output logic                   q_rd,
    input  logic [VALUE_WIDTH-1:0] item_stream,
    input  logic [LEN_W-1:0]       item_len,
    input  logic                   item_fin,
    input  logic                   item_lsb,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [7:0]             out_byte,
    output logic                   out_run_end,
    output logic                   out_stream_end
);

    localparam int WORK_W = VALUE_WIDTH + 8;
    localparam int CNT_W  = $clog2(VALUE_WIDTH + 8);

    logic              busy_reg, busy_next;
    logic [WORK_W-1:0] work_reg, work_next;
    logic [CNT_W-1:0]  bits_reg, bits_next;
    logic              fin_reg, fin_next;
    logic              lsb_reg, lsb_next;
    logic [7:0]        pend_byte_reg, pend_byte_next;
    logic [2:0]        pend_cnt_reg, pend_cnt_next;
    logic              out_valid_reg, out_valid_next;
    logic [7:0]        out_byte_reg, out_byte_next;
    logic              out_run_end_reg, out_run_end_next;
    logic              out_stream_end_reg, out_stream_end_next;

    logic              have;
    logic [WORK_W-1:0] cur_word;
    logic [CNT_W-1:0]  cur_bits;
    logic              cur_fin;
    logic              cur_lsb;
    logic [CNT_W-1:0]  rem;
    logic              full_byte, flush, emit, step, last_byte, done, slot_free;

    // Merge the pending bits in front of a freshly loaded item.
    // The pending byte keeps its bits at their output positions.
    always_comb
    begin
        if (busy_reg)
        begin
            cur_word = work_reg;
            cur_bits = bits_reg;
            cur_fin  = fin_reg;
            cur_lsb  = lsb_reg;
        end
        else
        begin
            cur_word = (WORK_W'(item_stream) << pend_cnt_reg) |
                       WORK_W'(item_lsb ? pend_byte_reg : rev8(pend_byte_reg));
            cur_bits = CNT_W'(item_len) + CNT_W'(pend_cnt_reg);
            cur_fin  = item_fin;
            cur_lsb  = item_lsb;
        end
    end

    assign have      = busy_reg || q_valid;
    assign slot_free = !out_valid_reg || out_ready;
    assign full_byte = (cur_bits >= CNT_W'(8));
    assign rem       = cur_bits - CNT_W'(8);
    assign flush     = !full_byte && cur_fin && (cur_bits != '0);
    assign emit      = have && (full_byte || flush);
    assign step      = have && (!emit || slot_free);
    assign last_byte = flush ||
                       (full_byte && (rem < CNT_W'(8)) && !(cur_fin && (rem != '0)));
    assign done      = step && (!emit || last_byte);
    assign q_rd      = step && !busy_reg;

    always_comb
    begin
        busy_next      = busy_reg;
        work_next      = work_reg;
        bits_next      = bits_reg;
        fin_next       = fin_reg;
        lsb_next       = lsb_reg;
        pend_byte_next = pend_byte_reg;
        pend_cnt_next  = pend_cnt_reg;
        if (step)
        begin
            busy_next = !done;
            work_next = cur_word >> 8;
            bits_next = rem;
            fin_next  = cur_fin;
            lsb_next  = cur_lsb;
            if (done)
            begin
                if (cur_fin)
                begin
                    pend_byte_next = '0;
                    pend_cnt_next  = '0;
                end
                else if (emit)
                begin
                    pend_byte_next = cur_lsb ? cur_word[15:8] : rev8(cur_word[15:8]);
                    pend_cnt_next  = rem[2:0];
                end
                else
                begin
                    pend_byte_next = cur_lsb ? cur_word[7:0] : rev8(cur_word[7:0]);
                    pend_cnt_next  = cur_bits[2:0];
                end
            end
        end
    end

    always_comb
    begin
        out_valid_next      = out_valid_reg;
        out_byte_next       = out_byte_reg;
        out_run_end_next    = out_run_end_reg;
        out_stream_end_next = out_stream_end_reg;
        if (step && emit)
        begin
            out_valid_next      = 1'b1;
            out_byte_next       = cur_lsb ? cur_word[7:0] : rev8(cur_word[7:0]);
            out_run_end_next    = last_byte;
            out_stream_end_next = last_byte && cur_fin;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            pend_byte_reg <= '0;
            pend_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            pend_byte_reg <= pend_byte_next;
            pend_cnt_reg  <= pend_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg           <= work_next;
        bits_reg           <= bits_next;
        fin_reg            <= fin_next;
        lsb_reg            <= lsb_next;
        out_byte_reg       <= out_byte_next;
        out_run_end_reg    <= out_run_end_next;
        out_stream_end_reg <= out_stream_end_next;
    end

    assign out_valid      = out_valid_reg;
    assign out_byte       = out_byte_reg;
    assign out_run_end    = out_run_end_reg;
    assign out_stream_end = out_stream_end_reg;

    `BFP_ASSERT_NOW(a_busy_has_byte, clk, rst_n, busy_reg, (bits_reg >= CNT_W'(8)) || (fin_reg && (bits_reg != '0)))
    `BFP_ASSERT_NOW(a_stream_end_in_run, clk, rst_n, out_valid_reg && out_stream_end_reg, out_run_end_reg)
    `BFP_ASSERT_NEXT(a_final_clears, clk, rst_n, done && cur_fin, (pend_cnt_reg == 3'd0) && !busy_reg)

endmodule

// File: design/bit_field_packer.sv
// Channel   | Dir | Payload
// s_axis    | in  | tdata: value_in, tlast: final_value
// m_axis    | out | tdata: packed_byte, tlast: run_end, tuser: stream_end
// apb       | in  | 0x0 bit_length, 0x4 lsb_first
//
// An input item enters the two-entry queue in the cycle it is accepted.
// The back end turns an item into 0 to 9 output bytes, at one byte per cycle
// while m_axis takes them; an item that makes no byte still passes through it.
// Output is registered, so a stalled m_axis holds the back end only while it
// has a byte to send; the queue keeps taking input until it is full.
// Reset clears the pending byte and loads bit_length = 8, lsb_first = 0.
module bit_field_packer
    import bfp_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [2:0]                          paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [((VALUE_WIDTH+7)/8)*8-1:0]    s_axis_tdata,   // value_in
    input  logic                                s_axis_tlast,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [7:0]                          m_axis_tdata,   // packed_byte
    output logic                                m_axis_tlast,
    output logic                                m_axis_tuser    // stream_end
);

    localparam int LEN_W  = $clog2(VALUE_WIDTH + 1);
    localparam int ITEM_W = VALUE_WIDTH + LEN_W + 2;

    bfp_cfg_t cfg_reg, cfg_next;
    reg_idx_t reg_idx;
    logic     cfg_wr;

    logic                   q_wr, q_full, q_valid, q_rd;
    logic [VALUE_WIDTH-1:0] f_stream, b_stream;
    logic [LEN_W-1:0]       f_len, b_len;
    logic                   f_fin, b_fin, f_lsb, b_lsb;
    logic [ITEM_W-1:0]      q_din, q_dout;

    assign pready  = 1'b1;
    assign reg_idx = reg_idx_t'(paddr[2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr)
        begin
            unique case (reg_idx)
                REG_BIT_LENGTH: cfg_next.bit_length = pwdata[CFG_LEN_W-1:0];
                REG_LSB_FIRST:  cfg_next.lsb_first  = pwdata[0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_BIT_LENGTH: prdata = 32'(cfg_reg.bit_length);
            REG_LSB_FIRST:  prdata = 32'(cfg_reg.lsb_first);
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.bit_length <= BIT_LENGTH_RST;
            cfg_reg.lsb_first  <= LSB_FIRST_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    bfp_front #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .LEN_W       (LEN_W)
    ) u_front (
        .cfg         (cfg_reg),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .value_in    (s_axis_tdata[VALUE_WIDTH-1:0]),
        .final_value (s_axis_tlast),
        .q_full      (q_full),
        .q_wr        (q_wr),
        .item_stream (f_stream),
        .item_len    (f_len),
        .item_fin    (f_fin),
        .item_lsb    (f_lsb)
    );

    assign q_din = {f_lsb, f_fin, f_len, f_stream};

    bfp_queue #(
        .DATA_W (ITEM_W)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (q_wr),
        .din      (q_din),
        .full     (q_full),
        .rd_valid (q_valid),
        .rd_en    (q_rd),
        .dout     (q_dout)
    );

    assign {b_lsb, b_fin, b_len, b_stream} = q_dout;

    bfp_back #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .LEN_W       (LEN_W)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_valid        (q_valid),
        .q_rd           (q_rd),
        .item_stream    (b_stream),
        .item_len       (b_len),
        .item_fin       (b_fin),
        .item_lsb       (b_lsb),
        .out_valid      (m_axis_tvalid),
        .out_ready      (m_axis_tready),
        .out_byte       (m_axis_tdata),
        .out_run_end    (m_axis_tlast),
        .out_stream_end (m_axis_tuser)
    );

endmodule
